FILE: hdl/box_corner_project_unit_defines.svh
// ----------------------------------------------------------------------------
// box corner projector assertion macros
// checks for the file that carries concurrent assertions
// ----------------------------------------------------------------------------
`ifndef BOX_CORNER_PROJECT_UNIT_DEFINES_SVH
`define BOX_CORNER_PROJECT_UNIT_DEFINES_SVH

// condition implies consequence in the same cycle
`define BCP_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("box corner projector check failed");

// condition implies consequence in the next cycle
`define BCP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("box corner projector check failed");

`endif

FILE: hdl/bcp_pkg.sv
// ----------------------------------------------------------------------------
// box corner projector package
// shared constants, codes and record types
// ----------------------------------------------------------------------------
package bcp_pkg;

   localparam int WORLD_FRAC_BITS = 8;
   localparam int PIXEL_FRAC_BITS = 4;
   localparam int CORNER_COUNT    = 8;
   localparam int CIDX_W          = $clog2(CORNER_COUNT);

   localparam int IN_DATA_W  = 96;
   localparam int OUT_DATA_W = 104;

   localparam int CAM_W     = 32;
   localparam int CSR_W     = 64;
   localparam int CSR_COUNT = 6;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW0_LO = 3'd0,
      CSR_ROW0_HI = 3'd1,
      CSR_ROW1_LO = 3'd2,
      CSR_ROW1_HI = 3'd3,
      CSR_ROW2_LO = 3'd4,
      CSR_ROW2_HI = 3'd5
   } csr_index_type;

   localparam logic [CSR_W-1:0] CAM_RESET [CSR_COUNT] = '{
      64'd65536, 64'd0, 64'd281474976710656, 64'd0, 64'd0, 64'd65536
   };

   // corner table, bit k belongs to corner k
   localparam logic [CORNER_COUNT-1:0] NEG_X_MASK = 8'b1000_0111;
   localparam logic [CORNER_COUNT-1:0] NEG_Y_MASK = 8'b1011_0001;
   localparam logic [CORNER_COUNT-1:0] TOP_MASK   = 8'b0110_0011;

   // quarter wave polynomial, Q1.14
   localparam int SINE_QUARTER = 16384;
   localparam int SINE_K0      = 10512;
   localparam int SINE_K1      = 1160;
   localparam int SINE_K2      = 25736;
   localparam int ROUND_HALF   = 8192;
   localparam int ROT_SHIFT    = 14;

   localparam int WORLD_W = 18;
   localparam int HEIGHT_W = 15;
   localparam int PROD_W  = CAM_W + WORLD_W + 1;
   localparam int ACC_W   = PROD_W + 2;
   localparam int PIX_W   = 24;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

   typedef struct packed {
      logic [CIDX_W-1:0]          index;
      logic signed [WORLD_W-1:0]  wx;
      logic signed [WORLD_W-1:0]  wy;
      logic [HEIGHT_W-1:0]        wz;
      logic                       last;
   } corner_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef enum logic [2:0] {
      FR_IDLE, FR_Z2, FR_Y1, FR_Y2, FR_SINE, FR_ROT, FR_EMIT
   } front_state_type;

   typedef enum logic [2:0] {
      BK_IDLE, BK_MUL, BK_SUM, BK_START, BK_DIV, BK_OUT
   } back_state_type;

endpackage

FILE: hdl/bcp_fifo.sv
// ----------------------------------------------------------------------------
// box corner projector corner queue
// small flop queue between the corner generator and the projector
// ----------------------------------------------------------------------------
module bcp_fifo
   import bcp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  corner_type push_data,
   input  logic       pop,
   output corner_type head,
   output logic       full,
   output logic       empty
);

   corner_type                mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]     wr_ptr_ff;
   logic [FIFO_PTR_W-1:0]     rd_ptr_ff;
   logic [FIFO_PTR_W:0]       count_ff;

   assign full  = (count_ff == (FIFO_PTR_W+1)'(FIFO_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hdl/bcp_front.sv
// ----------------------------------------------------------------------------
// box corner projector front end
// takes a box, evaluates sine and cosine, emits eight rotated corners
// ----------------------------------------------------------------------------
module bcp_front
   import bcp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [IN_DATA_W-1:0] req_tdata,
   output logic                 push,
   output corner_type           push_data,
   input  logic                 fifo_full
);

   front_state_type state_ff, state_in;

   logic [14:0]        hx_ff, hy_ff, hz_ff;
   logic signed [15:0] cx_ff, cy_ff;
   logic [14:0]        t_s_ff, t_c_ff;
   logic               neg_s_ff, neg_c_ff;
   logic [14:0]        z2_s_ff, z2_c_ff;
   logic [14:0]        y_s_ff, y_c_ff;
   logic signed [15:0] sin_ff, cos_ff;
   logic signed [31:0] chx_ff, shy_ff, shx_ff, chy_ff;
   logic [CIDX_W-1:0]  k_ff;

   logic        accept;
   logic [15:0] yaw, yaw_c;
   logic [29:0] sq_s, sq_c, m2_s, m2_c, m3_s, m3_c;
   logic [25:0] m1_s, m1_c;
   logic        nx, ny, is_last;
   logic signed [32:0] ax, ay, rx, ry;

   assign yaw    = req_tdata[92:77];
   assign yaw_c  = yaw + 16'(SINE_QUARTER);
   assign accept = req_tvalid && req_tready;

   assign sq_s = t_s_ff * t_s_ff;
   assign sq_c = t_c_ff * t_c_ff;
   assign m1_s = 26'(z2_s_ff) * 26'(SINE_K1);
   assign m1_c = 26'(z2_c_ff) * 26'(SINE_K1);
   assign m2_s = 30'(z2_s_ff) * 30'(y_s_ff);
   assign m2_c = 30'(z2_c_ff) * 30'(y_c_ff);
   assign m3_s = 30'(t_s_ff) * 30'(y_s_ff);
   assign m3_c = 30'(t_c_ff) * 30'(y_c_ff);

   assign nx      = NEG_X_MASK[k_ff];
   assign ny      = NEG_Y_MASK[k_ff];
   assign is_last = (k_ff == CIDX_W'(CORNER_COUNT - 1));

   // x' = c*lx + s*ly, y' = -s*lx + c*ly, rounded to world format
   assign ax = (nx ? -33'(chx_ff) : 33'(chx_ff)) + (ny ? -33'(shy_ff) : 33'(shy_ff));
   assign ay = (nx ? 33'(shx_ff) : -33'(shx_ff)) + (ny ? -33'(chy_ff) : 33'(chy_ff));
   assign rx = (ax + 33'sd8192) >>> ROT_SHIFT;
   assign ry = (ay + 33'sd8192) >>> ROT_SHIFT;

   assign push = (state_ff == FR_EMIT) && !fifo_full;
   assign push_data.index = k_ff;
   assign push_data.wx    = WORLD_W'(rx) + WORLD_W'(cx_ff);
   assign push_data.wy    = WORLD_W'(ry) + WORLD_W'(cy_ff);
   assign push_data.wz    = TOP_MASK[k_ff] ? hz_ff : '0;
   assign push_data.last  = is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         FR_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) state_in = FR_Z2;
         end
         FR_Z2:   state_in = FR_Y1;
         FR_Y1:   state_in = FR_Y2;
         FR_Y2:   state_in = FR_SINE;
         FR_SINE: state_in = FR_ROT;
         FR_ROT:  state_in = FR_EMIT;
         FR_EMIT: begin
            // the last corner leaves and the next box comes in together
            req_tready = !fifo_full && is_last;
            if (!fifo_full && is_last) begin
               state_in = req_tvalid ? FR_Z2 : FR_IDLE;
            end
         end
         default: state_in = FR_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hx_ff    <= req_tdata[14:0];
         hy_ff    <= req_tdata[29:15];
         hz_ff    <= req_tdata[44:30];
         cx_ff    <= req_tdata[60:45];
         cy_ff    <= req_tdata[76:61];
         t_s_ff   <= yaw[14] ? 15'(SINE_QUARTER) - {1'b0, yaw[13:0]} : {1'b0, yaw[13:0]};
         t_c_ff   <= yaw_c[14] ? 15'(SINE_QUARTER) - {1'b0, yaw_c[13:0]}
                               : {1'b0, yaw_c[13:0]};
         neg_s_ff <= yaw[15];
         neg_c_ff <= yaw_c[15];
      end
      if (state_ff == FR_Z2) begin
         z2_s_ff <= sq_s[28:14];
         z2_c_ff <= sq_c[28:14];
      end
      if (state_ff == FR_Y1) begin
         y_s_ff <= 15'(SINE_K0) - 15'(m1_s[25:14]);
         y_c_ff <= 15'(SINE_K0) - 15'(m1_c[25:14]);
      end
      if (state_ff == FR_Y2) begin
         y_s_ff <= 15'(SINE_K2) - m2_s[28:14];
         y_c_ff <= 15'(SINE_K2) - m2_c[28:14];
      end
      if (state_ff == FR_SINE) begin
         sin_ff <= neg_s_ff ? -$signed(m3_s[29:14]) : $signed(m3_s[29:14]);
         cos_ff <= neg_c_ff ? -$signed(m3_c[29:14]) : $signed(m3_c[29:14]);
      end
      if (state_ff == FR_ROT) begin
         chx_ff <= cos_ff * $signed({1'b0, hx_ff});
         shy_ff <= sin_ff * $signed({1'b0, hy_ff});
         shx_ff <= sin_ff * $signed({1'b0, hx_ff});
         chy_ff <= cos_ff * $signed({1'b0, hy_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
      end else if (push) begin
         k_ff <= k_ff + 1'b1;
      end
   end

endmodule

FILE: hdl/bcp_div.sv
// ----------------------------------------------------------------------------
// box corner projector pixel divider
// rounded signed quotient num * 2^frac / den, one bit per cycle, saturating
// ----------------------------------------------------------------------------
module bcp_div
   import bcp_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [ACC_W-1:0] num,
   input  logic signed [ACC_W-1:0] den,
   output div_status_type          status,
   output logic [PIX_W-1:0]        quot
);

   localparam int NUM_W = ACC_W + PIXEL_FRAC_BITS + 1;
   localparam int SH_W  = ACC_W + PIX_W + 1;
   localparam int CNT_W = $clog2(PIX_W + 1);

   logic [NUM_W-1:0]  rem_ff;
   logic [SH_W-2:0]   dsh_ff;
   logic [PIX_W-1:0]  q_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              neg_ff, big_ff, done_ff;

   logic [ACC_W-1:0]  an, ad;
   logic [NUM_W-1:0]  nn;
   logic              fits;

   assign an = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
   assign ad = den[ACC_W-1] ? ACC_W'(-den) : ACC_W'(den);
   // 2*|n|*2^frac + |d| over 2*|d| rounds half away from zero
   assign nn = (NUM_W'(an) << (PIXEL_FRAC_BITS + 1)) + NUM_W'(ad);
   assign fits = ((SH_W-1)'(rem_ff) >= dsh_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            cnt_ff <= CNT_W'(PIX_W);
         end else if (cnt_ff != '0) begin
            cnt_ff  <= cnt_ff - 1'b1;
            done_ff <= (cnt_ff == CNT_W'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= num[ACC_W-1] ^ den[ACC_W-1];
         // quotient of 2^PIX_W or more saturates either way
         big_ff <= (SH_W'(nn) >= (SH_W'(ad) << (PIX_W + 1)));
         rem_ff <= nn;
         dsh_ff <= (SH_W-1)'(ad) << PIX_W;
         q_ff   <= '0;
      end else if (cnt_ff != '0) begin
         if (fits) begin
            rem_ff <= rem_ff - NUM_W'(dsh_ff);
         end
         q_ff   <= {q_ff[PIX_W-2:0], fits};
         dsh_ff <= dsh_ff >> 1;
      end
   end

   assign status.busy = (cnt_ff != '0);
   assign status.done = done_ff;

   always_comb begin
      if (neg_ff) begin
         if (big_ff || (q_ff[PIX_W-1] && (q_ff[PIX_W-2:0] != '0))) begin
            quot = {1'b1, {(PIX_W-1){1'b0}}};
         end else begin
            quot = -q_ff;
         end
      end else begin
         if (big_ff || q_ff[PIX_W-1]) begin
            quot = {1'b0, {(PIX_W-1){1'b1}}};
         end else begin
            quot = q_ff;
         end
      end
   end

endmodule

FILE: hdl/bcp_back.sv
// ----------------------------------------------------------------------------
// box corner projector back end
// camera transform, perspective divide and result register
// ----------------------------------------------------------------------------
module bcp_back
   import bcp_pkg::*;
(
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             fifo_empty,
   output logic                             fifo_pop,
   input  corner_type                       fifo_head,
   input  logic [CSR_COUNT-1:0][CSR_W-1:0]  cam,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [OUT_DATA_W-1:0]            rsp_tdata,
   output logic                             rsp_tuser,
   output logic                             rsp_tlast
);

   back_state_type state_ff, state_in;

   corner_type              cur_ff;
   logic signed [PROD_W-1:0] prod_ff [3][3];
   logic signed [ACC_W-1:0]  acc_ff [3];
   logic                     invalid_ff;

   logic                     out_valid_ff;
   logic [OUT_DATA_W-1:0]    out_data_ff;
   logic                     out_user_ff, out_last_ff;

   logic signed [WORLD_W:0]  opnd [3];
   logic                     div_start, out_load;
   div_status_type           st_u, st_v;
   logic [PIX_W-1:0]         q_u, q_v;

   assign opnd[0] = (WORLD_W+1)'(cur_ff.wx);
   assign opnd[1] = (WORLD_W+1)'(cur_ff.wy);
   assign opnd[2] = $signed({{(WORLD_W+1-HEIGHT_W){1'b0}}, cur_ff.wz});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      fifo_pop  = 1'b0;
      div_start = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            fifo_pop = !fifo_empty;
            if (!fifo_empty) state_in = BK_MUL;
         end
         BK_MUL:   state_in = BK_SUM;
         BK_SUM:   state_in = BK_START;
         BK_START: begin
            div_start = 1'b1;
            state_in  = BK_DIV;
         end
         BK_DIV: begin
            if (st_u.done && st_v.done) state_in = BK_OUT;
         end
         BK_OUT: begin
            // result register frees as the receiver takes its transaction
            out_load = !out_valid_ff || rsp_tready;
            if (out_load) state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (fifo_pop) begin
         cur_ff <= fifo_head;
      end
      if (state_ff == BK_MUL) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               prod_ff[r][c] <= $signed(cam[2*r + (c >> 1)][CAM_W*(c & 1) +: CAM_W])
                                * opnd[c];
            end
         end
      end
      if (state_ff == BK_SUM) begin
         for (int r = 0; r < 3; r++) begin
            acc_ff[r] <= ACC_W'(prod_ff[r][0]) + ACC_W'(prod_ff[r][1])
                       + ACC_W'(prod_ff[r][2])
                       + (ACC_W'($signed(cam[2*r + 1][2*CAM_W-1:CAM_W])) <<< WORLD_FRAC_BITS);
         end
      end
      if (div_start) begin
         invalid_ff <= (acc_ff[2] == '0);
      end
   end

   bcp_div u_div_u (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (acc_ff[0]),
      .den    (acc_ff[2]),
      .status (st_u),
      .quot   (q_u)
   );

   bcp_div u_div_v (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (acc_ff[1]),
      .den    (acc_ff[2]),
      .status (st_v),
      .quot   (q_v)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_data_ff <= {2'b00,
                         invalid_ff ? {PIX_W{1'b0}} : q_v,
                         invalid_ff ? {PIX_W{1'b0}} : q_u,
                         cur_ff.wz, cur_ff.wy, cur_ff.wx, cur_ff.index};
         out_user_ff <= invalid_ff;
         out_last_ff <= cur_ff.last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

FILE: hdl/box_corner_project_unit.sv
// ----------------------------------------------------------------------------
// box corner projector
// projects the eight corners of a yawed box through a 3x4 camera matrix
// ----------------------------------------------------------------------------
// req channel: one box per transaction on req_tdata. rsp channel: eight
// transactions per box, corners 0 to 7 in order, rsp_tlast on corner 7,
// rsp_tuser set when the homogeneous divisor is zero (pixels then read 0).
// csr port: csr_wen writes csr_wdata into camera register csr_index; write
// only while no box is in flight. Indexes past the last register are dropped.
// Front end: a box is taken, sine and cosine settle in the Z2, Y1, Y2 and SINE
// states, the rotation products in ROT, then one corner per cycle goes into a
// 4-entry queue while it is not full. Back end: each corner goes through pop,
// products, sums, divider start, the bit-serial divider and the result
// register, and the next corner is popped only after that register is loaded.
// The serial divider pair in the back end sets the throughput.
// Reset clears control state and loads the identity camera; no clearing pass.
// When the receiver stalls, the result register holds, the back end waits,
// the queue fills and then req_tready drops; nothing is lost.
// ----------------------------------------------------------------------------
`include "box_corner_project_unit_defines.svh"

module box_corner_project_unit
   import bcp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // half_x, half_y, box_height, center_x, center_y, yaw, zero pad
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [IN_DATA_W-1:0]  req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // corner_index, world_x, world_y, world_z, pixel_u, pixel_v, zero pad
   output logic [OUT_DATA_W-1:0] rsp_tdata,
   // proj_invalid
   output logic                  rsp_tuser,
   output logic                  rsp_tlast,
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]      csr_wdata
);

   logic [CSR_COUNT-1:0][CSR_W-1:0] cam_ff;

   logic       fifo_push, fifo_pop, fifo_full, fifo_empty;
   corner_type push_data, fifo_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CSR_COUNT; i++) begin
            cam_ff[i] <= CAM_RESET[i];
         end
      end else if (csr_wen) begin
         unique case (csr_index_type'(csr_index))
            CSR_ROW0_LO: cam_ff[CSR_ROW0_LO] <= csr_wdata;
            CSR_ROW0_HI: cam_ff[CSR_ROW0_HI] <= csr_wdata;
            CSR_ROW1_LO: cam_ff[CSR_ROW1_LO] <= csr_wdata;
            CSR_ROW1_HI: cam_ff[CSR_ROW1_HI] <= csr_wdata;
            CSR_ROW2_LO: cam_ff[CSR_ROW2_LO] <= csr_wdata;
            CSR_ROW2_HI: cam_ff[CSR_ROW2_HI] <= csr_wdata;
            default: ;
         endcase
      end
   end

   bcp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push       (fifo_push),
      .push_data  (push_data),
      .fifo_full  (fifo_full)
   );

   bcp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_data (push_data),
      .pop       (fifo_pop),
      .head      (fifo_head),
      .full      (fifo_full),
      .empty     (fifo_empty)
   );

   bcp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .fifo_empty (fifo_empty),
      .fifo_pop   (fifo_pop),
      .fifo_head  (fifo_head),
      .cam        (cam_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   `BCP_ASSERT_SAME(a_invalid_zero_pixels, rsp_tvalid && rsp_tuser, rsp_tdata[101:54] == '0)
   `BCP_ASSERT_SAME(a_last_is_final_corner, rsp_tvalid && rsp_tlast, rsp_tdata[2:0] == CIDX_W'(CORNER_COUNT - 1))
   `BCP_ASSERT_SAME(a_queue_no_overflow, fifo_push, !fifo_full)
   `BCP_ASSERT_NEXT(a_front_busy_after_accept, req_tvalid && req_tready, !req_tready)

endmodule
